// ===== sv/arq_pkg.sv =====
// Shared types and constants for the affine requantizer.
// Used by every module of the block except arq_checker; depends on nothing.
package arq_pkg;

	localparam int PIXEL_W = 8;
	localparam int WORD_W = 32;
	localparam int PROD_W = 64;
	localparam int MULT_W = 31;
	localparam int SHIFT_W = 6;
	localparam int CFG_DATA_W = 31;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_MULTIPLIER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHIFT_AMOUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_ZERO_POINT = 2'd2;

	localparam logic [MULT_W-1:0] MULT_RESET = 31'd1073741824;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd31;
	localparam logic [PIXEL_W-1:0] ZP_RESET = 8'd0;

	typedef struct packed {
		logic [MULT_W-1:0] multiplier;
		logic [SHIFT_W-1:0] shift_amount;
		logic [PIXEL_W-1:0] out_zero_point;
	} arq_cfg_t;

endpackage

// ===== sv/arq_affine.sv =====
// Stage 1: affine step a = pixel * scale + bias, wrapping modulo 2^32.
// Depends on arq_pkg.
module arq_affine
	import arq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [PIXEL_W-1:0]       pixel,
	input  logic signed [WORD_W-1:0] chan_scale,
	input  logic signed [WORD_W-1:0] chan_bias,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [WORD_W-1:0]        acc
);

	logic              v_s1;
	logic [WORD_W-1:0] acc_s1;
	logic [WORD_W-1:0] acc_next;

	// Only the low 32 bits of the product and sum are kept.
	assign acc_next = WORD_W'({{(WORD_W-PIXEL_W){1'b0}}, pixel} * $unsigned(chan_scale))
		+ $unsigned(chan_bias);

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			acc_s1 <= acc_next;
		end
	end

	assign out_valid = v_s1;
	assign acc = acc_s1;

endmodule

// ===== sv/arq_mul.sv =====
// Stage 2: signed 32-bit accumulator times the unsigned 31-bit multiplier.
// Depends on arq_pkg.
module arq_mul
	import arq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  arq_cfg_t           cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WORD_W-1:0]  acc,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PROD_W-1:0]  prod
);

	logic                     v_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic signed [PROD_W-1:0] prod_next;

	// Both operands are 32-bit signed; the product always fits in 64 bits.
	assign prod_next = $signed(acc) * $signed({1'b0, cfg.multiplier});

	assign in_ready = !v_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (in_ready) begin
			v_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			prod_s2 <= $unsigned(prod_next);
		end
	end

	assign out_valid = v_s2;
	assign prod = prod_s2;

endmodule

// ===== sv/arq_round_shift.sv =====
// Stages 3 and 4: add the round-half-up offset, then shift right arithmetically.
// Depends on arq_pkg.
module arq_round_shift
	import arq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  arq_cfg_t           cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PROD_W-1:0]  prod,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WORD_W-1:0]  shifted
);

	logic              v_s3;
	logic              v_s4;
	logic              rdy_s4;
	logic [PROD_W-1:0] sum_s3;
	logic [WORD_W-1:0] shifted_s4;
	logic [PROD_W-1:0] rnd;
	logic [PROD_W-1:0] shifted_full;

	// A zero shift adds no offset and passes the product through.
	assign rnd = (cfg.shift_amount == '0) ? '0
		: (PROD_W'(1) << (cfg.shift_amount - SHIFT_W'(1)));

	assign shifted_full = $unsigned($signed(sum_s3) >>> cfg.shift_amount);

	assign rdy_s4 = !v_s4 || out_ready;
	assign in_ready = !v_s3 || rdy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s3 <= in_valid;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			sum_s3 <= prod + rnd;
		end
		if (rdy_s4 && v_s3) begin
			shifted_s4 <= shifted_full[WORD_W-1:0];
		end
	end

	assign out_valid = v_s4;
	assign shifted = shifted_s4;

endmodule

// ===== sv/arq_clamp.sv =====
// Stage 5: add the output zero point and saturate the low word to 0..255.
// Depends on arq_pkg.
module arq_clamp
	import arq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  arq_cfg_t           cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [WORD_W-1:0]  shifted,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIXEL_W-1:0] result
);

	logic               v_s5;
	logic [PIXEL_W-1:0] result_s5;
	logic [WORD_W-1:0]  r32;
	logic [PIXEL_W-1:0] sat;

	assign r32 = shifted + {{(WORD_W-PIXEL_W){1'b0}}, cfg.out_zero_point};

	// The low word is read as signed: negative clamps to 0, large to 255.
	always_comb begin
		if (r32[WORD_W-1]) begin
			sat = '0;
		end else if (|r32[WORD_W-2:PIXEL_W]) begin
			sat = '1;
		end else begin
			sat = r32[PIXEL_W-1:0];
		end
	end

	assign in_ready = !v_s5 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (in_ready) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_s5 <= sat;
		end
	end

	assign out_valid = v_s5;
	assign result = result_s5;

endmodule

// ===== sv/affine_requantize_u8.sv =====
// Top level of the affine requantizer: configuration registers and five-stage pipeline.
// Depends on arq_pkg, arq_affine, arq_mul, arq_round_shift and arq_clamp.
//
// Usage:
// Input channel (in_valid, in_stall, pixel, chan_scale, chan_bias) carries one
// activation with its channel's scale and bias; a transfer happens on a rising
// edge with in_valid high and in_stall low. Output channel (out_valid,
// out_stall, out_pixel) returns one requantized byte per input, in order.
// From input transfer to out_valid an item passes these stages: affine multiply-add,
// 32x31 multiply, rounding add, arithmetic shift, zero-point add and clamp,
// one register stage each. Throughput is one item per cycle while the receiver
// does not stall; the 32x31 multiplier stage sets the clock-rate limit.
// When the receiver stalls, each stage holds its item and the stages behind it
// keep filling empty slots; in_stall rises only once all five stages are full.
// The configuration port (cfg_we, cfg_index, cfg_data) writes multiplier,
// shift amount and output zero point; write only while the pipeline is empty.
// Unknown indexes are ignored. Reset empties the pipeline and loads the
// multiplier with 2^30, the shift with 31 and the zero point with 0.
module affine_requantize_u8
	import arq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [PIXEL_W-1:0]       pixel,
	input  logic signed [WORD_W-1:0] chan_scale,
	input  logic signed [WORD_W-1:0] chan_bias,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [PIXEL_W-1:0]       out_pixel
);

	arq_cfg_t          cfg_q;
	logic              in_ready;
	logic              v1, r1;
	logic              v2, r2;
	logic              v4, r4;
	logic [WORD_W-1:0] acc;
	logic [PROD_W-1:0] prod;
	logic [WORD_W-1:0] shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.multiplier <= MULT_RESET;
			cfg_q.shift_amount <= SHIFT_RESET;
			cfg_q.out_zero_point <= ZP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MULTIPLIER:     cfg_q.multiplier <= cfg_data[MULT_W-1:0];
				CFG_SHIFT_AMOUNT:   cfg_q.shift_amount <= cfg_data[SHIFT_W-1:0];
				CFG_OUT_ZERO_POINT: cfg_q.out_zero_point <= cfg_data[PIXEL_W-1:0];
				default: ;
			endcase
		end
	end

	arq_affine u_affine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel      (pixel),
		.chan_scale (chan_scale),
		.chan_bias  (chan_bias),
		.out_valid  (v1),
		.out_ready  (r1),
		.acc        (acc)
	);

	arq_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v1),
		.in_ready  (r1),
		.acc       (acc),
		.out_valid (v2),
		.out_ready (r2),
		.prod      (prod)
	);

	arq_round_shift u_round_shift (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v2),
		.in_ready  (r2),
		.prod      (prod),
		.out_valid (v4),
		.out_ready (r4),
		.shifted   (shifted)
	);

	arq_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (v4),
		.in_ready  (r4),
		.shifted   (shifted),
		.out_valid (out_valid),
		.out_ready (!out_stall),
		.result    (out_pixel)
	);

	assign in_stall = !in_ready;

endmodule

// ===== sv/arq_checker.sv =====
// Port-level checker for the affine requantizer, bound to the top level.
// Depends on affine_requantize_u8 and its ports only.
module arq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_pixel
);

	// A stalled result stays presented and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_pixel))
		else $error("stalled result changed or dropped");

	// The input only backs up when a result is waiting on a stalled receiver.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// With the receiver free, an accepted item reaches out_valid once it has passed every pipeline stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
		##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

	// After reset the pipeline is empty and the input is free.
	assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid && !in_stall)
		else $error("pipeline not empty after reset");

endmodule

bind affine_requantize_u8 arq_checker u_arq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_pixel (out_pixel)
);

// ===== bench/testbench.sv =====
// Self-checking testbench for affine_requantize_u8: directed and random pixel streams.
// Depends on arq_pkg and the affine_requantize_u8 RTL; predicts each output byte itself.
`timescale 1ns / 100ps

module testbench
	import arq_pkg::*;
();

	localparam int CLK_PERIOD = 12;
	localparam int PIPE_LATENCY = 5;
	localparam int TIMEOUT_CYCLES = 600000;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [MULT_W-1:0] MULT_MAX = 31'h7FFFFFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [PIXEL_W-1:0] pixel;
	logic signed [WORD_W-1:0] chan_scale;
	logic signed [WORD_W-1:0] chan_bias;
	logic out_valid;
	logic out_stall;
	logic [PIXEL_W-1:0] out_pixel;

	// Local copy of the requantizer settings, updated on every register write.
	logic [MULT_W-1:0] model_mult;
	logic [SHIFT_W-1:0] model_shift;
	logic [PIXEL_W-1:0] model_zp;

	logic [PIXEL_W-1:0] pending_pixels[$];
	int error_count = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit rx_hold = 1'b0;
	int stall_left = 0;

	affine_requantize_u8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.chan_scale(chan_scale),
		.chan_bias(chan_bias),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_pixel(out_pixel)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [PIXEL_W-1:0] requant_pixel(input logic [PIXEL_W-1:0] px,
			input logic [WORD_W-1:0] sc, input logic [WORD_W-1:0] bi);
		logic [31:0] acc;
		logic [63:0] prod;
		logic signed [63:0] t;
		logic [31:0] low;
		acc = {24'd0, px} * sc + bi;
		// The low 64 bits of the product are the same for signed and unsigned operands.
		prod = {{32{acc[31]}}, acc} * {33'd0, model_mult};
		t = prod;
		if (model_shift != '0) begin
			t = t + (64'd1 << (model_shift - 6'd1));
			t = t >>> model_shift;
		end
		t = t + {56'd0, model_zp};
		low = t[31:0];
		if (low[31])
			return 8'd0;
		else if (low > 32'd255)
			return 8'd255;
		return low[7:0];
	endfunction

	// Mostly no gap, sometimes a short or medium one, rarely a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Signed word of random magnitude, so both small and full-range values occur.
	function automatic logic [WORD_W-1:0] rand_word();
		int unsigned w;
		logic signed [31:0] v;
		w = $urandom_range(1, 32);
		v = $urandom;
		return v >>> (32 - w);
	endfunction

	function automatic logic [PIXEL_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return PIXEL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function void note_mismatch(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endfunction

	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic [WORD_W-1:0] sc,
			input logic [WORD_W-1:0] bi);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		pixel <= px;
		chan_scale <= sc;
		chan_bias <= bi;
		do
			@(posedge clk);
		while (in_stall);
		pending_pixels.push_back(requant_pixel(px, sc, bi));
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MULTIPLIER: model_mult = data[MULT_W-1:0];
			CFG_SHIFT_AMOUNT: model_shift = data[SHIFT_W-1:0];
			CFG_OUT_ZERO_POINT: model_zp = data[PIXEL_W-1:0];
			default: ;
		endcase
	endtask

	// Upper data bits beyond the shift and zero-point widths carry junk that must be dropped.
	task automatic set_config(input logic [MULT_W-1:0] mult, input logic [SHIFT_W-1:0] shift,
			input logic [PIXEL_W-1:0] zp);
		wait_for_results();
		write_reg(CFG_MULTIPLIER, mult);
		write_reg(CFG_SHIFT_AMOUNT, (31'($urandom) & ~31'h3F) | 31'(shift));
		write_reg(CFG_OUT_ZERO_POINT, (31'($urandom) & ~31'hFF) | 31'(zp));
	endtask

	task automatic long_hold(input int cycles);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		rx_hold = 1'b0;
	endtask

	task automatic test_reset_values();
		send_pixel(8'd0, 32'd0, 32'd0);
		send_pixel(8'd255, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_pixel(8'd255, 32'h80000000, 32'h80000000);
		send_pixel(8'd1, 32'd0, 32'h000001FF);
		send_pixel(8'd1, 32'd0, 32'hFFFFFFFF);
		send_pixel(8'd128, 32'd1, 32'd100);
	endtask

	// Without a shift the product passes through and only its low word is clamped.
	task automatic test_zero_shift();
		set_config(MULT_MAX, 6'd0, 8'd255);
		send_pixel(8'd0, 32'd0, 32'd0);
		send_pixel(8'd1, 32'd0, 32'd1);
		send_pixel(8'd2, 32'd1, 32'hFFFFFFFD);
	endtask

	task automatic test_deepest_shift();
		set_config(MULT_MAX, 6'd63, 8'd0);
		send_pixel(8'd0, 32'd0, 32'h80000000);
		send_pixel(8'd255, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_pixel(8'd255, 32'h80000000, 32'h80000000);
	endtask

	task automatic test_register_writes();
		set_config(31'd0, 6'd1, 8'd200);
		send_pixel(8'd77, 32'h12345678, 32'h9ABCDEF0);
		wait_for_results();
		// A write to the unused index must leave all settings as they were.
		write_reg(CFG_UNUSED, 31'h7FFFFFFF);
		send_pixel(8'd200, 32'h00001000, 32'hFFFF0000);
		set_config(MULT_RESET, SHIFT_RESET, ZP_RESET);
		send_pixel(8'd3, 32'd40, 32'hFFFFFF00);
	endtask

	// The receiver holds off long enough for the pipeline to fill and stall the input.
	task automatic test_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		fork
			long_hold(80);
			repeat (40) send_pixel(rand_pixel(), rand_word(), rand_word());
		join
		wait_for_results();
	endtask

	task automatic test_random_stream();
		logic [MULT_W-1:0] mult;
		logic [SHIFT_W-1:0] shift;
		logic [PIXEL_W-1:0] zp;
		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 4))
				0: mult = 31'd0;
				1: mult = MULT_MAX;
				2: mult = MULT_W'($urandom_range(32'h40000000, 32'h7FFFFFFF));
				default: mult = 31'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: shift = 6'd0;
				1: shift = 6'd63;
				2: shift = SHIFT_W'($urandom_range(1, 63));
				default: shift = SHIFT_W'($urandom_range(28, 50));
			endcase
			case ($urandom_range(0, 3))
				0: zp = 8'd0;
				1: zp = 8'd255;
				default: zp = PIXEL_W'($urandom_range(0, 255));
			endcase
			set_config(mult, shift, zp);
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			repeat (100) send_pixel(rand_pixel(), rand_word(), rand_word());
		end
	endtask

	always @(negedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			if (rx_idle)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_out
		logic [PIXEL_W-1:0] exp_pixel;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				note_mismatch($sformatf("unexpected transfer: out_pixel %0d", out_pixel));
			end else begin
				exp_pixel = pending_pixels.pop_front();
				if (out_pixel !== exp_pixel)
					note_mismatch($sformatf("out_pixel mismatch: expected %0d, got %0d",
						exp_pixel, out_pixel));
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MULTIPLIER;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel = '0;
		chan_scale = '0;
		chan_bias = '0;
		out_stall = 1'b0;
		model_mult = MULT_RESET;
		model_shift = SHIFT_RESET;
		model_zp = ZP_RESET;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_values();
		test_zero_shift();
		test_deepest_shift();
		test_register_writes();
		test_backpressure();
		test_random_stream();
		wait_for_results();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/arq_pkg.sv
sv/arq_affine.sv
sv/arq_mul.sv
sv/arq_round_shift.sv
sv/arq_clamp.sv
sv/affine_requantize_u8.sv
sv/arq_checker.sv
bench/testbench.sv
